>>> hdl/tpr_pkg.sv
// shared constants, codes and types of the tick paced level ramp
`default_nettype none

package tpr_pkg;

    localparam int FRACTION_BITS_DEF = 15;
    localparam int DATA_W            = 16;
    localparam int MODE_W            = 2;
    localparam int IDX_W             = 2;
    localparam int CNT_W             = 16;
    localparam int DIV_STEPS         = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_SET   = 2'd2
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_FADE_TARGET = 2'd0,
        REG_FADE_STEP   = 2'd1,
        REG_STEP_PERIOD = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic big;
    } unit_stat_t;

endpackage

`default_nettype wire

>>> hdl/tpr_serial_unit.sv
// bit-serial divide of the tick deficit with a serial multiply of the step count
`default_nettype none

module tpr_serial_unit #(
    parameter int FRACTION_BITS = tpr_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tpr_pkg::CNT_W-1:0]   dividend,
    input  logic [tpr_pkg::CNT_W-1:0]   divisor,
    input  logic [tpr_pkg::DATA_W-1:0]  step,
    output logic [tpr_pkg::CNT_W-1:0]   rem,
    output logic [FRACTION_BITS:0]      move,
    output tpr_pkg::unit_stat_t         stat
);
    import tpr_pkg::*;

    localparam int MOVE_W = FRACTION_BITS + 1;
    localparam int SUM_W  = ((MOVE_W + 1 > DATA_W) ? MOVE_W + 1 : DATA_W) + 1;
    localparam int CTR_W  = $clog2(DIV_STEPS + 1);
    localparam logic [CTR_W-1:0] LAST = CTR_W'(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              big_reg, big_next;
    logic [CTR_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic [MOVE_W-1:0] acc_reg, acc_next;

    logic              fin;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic              add_bit;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum;

    always_comb begin
        fin     = (cnt_reg == LAST);
        trial   = {rem_reg, dvd_reg[CNT_W-1]} - {1'b0, divisor};
        q_bit   = !trial[CNT_W];
        // last pass adds one more step for the plus one in the step count
        add_bit = fin ? 1'b1 : q_bit;
        base    = fin ? SUM_W'(acc_reg) : (SUM_W'(acc_reg) << 1);
        sum     = base + (add_bit ? SUM_W'(step) : SUM_W'(0));
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        big_next  = big_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            big_next  = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            acc_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CTR_W'(1);
            acc_next = sum[MOVE_W-1:0];
            // sticky overflow: any product this large passes every distance
            if (sum[SUM_W-1:MOVE_W] != '0) begin
                big_next = 1'b1;
            end
            if (fin) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                dvd_next = dvd_reg << 1;
                rem_next = q_bit ? trial[CNT_W-1:0] : {rem_reg[CNT_W-2:0], dvd_reg[CNT_W-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        big_reg <= big_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign rem       = rem_reg;
    assign move      = acc_reg;
    assign stat.done = done_reg;
    assign stat.big  = big_reg;

endmodule

`default_nettype wire

>>> hdl/tick_paced_level_ramp.sv
// top level of the tick paced level ramp with config registers and result register
// an item passes eval and emit, or for a tick that underflows the countdown, eval,
//   16 serial divide steps, one add for the plus one, update and emit
// one item in flight: a new input is taken only after the last result is loaded,
//   and the next input is taken while a result waits
// reset: synchronous active low aresetn clears config, level, goal, countdown, handshakes
`default_nettype none

module tick_paced_level_ramp #(
    parameter int FRACTION_BITS = tpr_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tpr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tpr_pkg::DATA_W-1:0]  cfg_data,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tpr_pkg::MODE_W-1:0]  s_mode,
    input  logic [tpr_pkg::DATA_W-1:0]  s_value,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tpr_pkg::DATA_W-1:0]  m_level,
    output logic                        m_settled,
    output logic                        m_fading,
    output logic                        m_at_full,
    output logic                        m_at_empty,
    output logic [tpr_pkg::CNT_W-1:0]   m_ticks_left
);
    import tpr_pkg::*;

    localparam int LVL_W = FRACTION_BITS + 1;
    localparam int CMP_W = (LVL_W > DATA_W) ? LVL_W : DATA_W;
    localparam logic [LVL_W-1:0] FULL     = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [CMP_W-1:0] FULL_EXT = CMP_W'(FULL);

    // config registers
    logic [DATA_W-1:0] fade_target_reg, fade_step_reg, step_period_reg;

    // ramp state
    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  goal_reg, goal_next;
    logic [CNT_W-1:0]  countdown_reg, countdown_next;

    // captured item
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] value_reg;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] out_level_reg;
    logic              out_settled_reg, out_fading_reg, out_full_reg, out_empty_reg;
    logic [CNT_W-1:0]  out_ticks_reg;

    // control
    logic              take_in;
    logic              unit_start;
    logic              load_out;
    logic              need_div;
    logic              tick_live;

    // datapath
    logic [CMP_W-1:0]  value_ext, target_ext;
    logic [LVL_W-1:0]  value_sat, target_sat;
    logic [CNT_W-1:0]  deficit;
    logic [CNT_W-1:0]  unit_rem;
    logic [LVL_W-1:0]  unit_move;
    unit_stat_t        unit_stat;
    logic              rising;
    logic [LVL_W-1:0]  gap_to_goal;
    logic              fading;

    tpr_serial_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .dividend (deficit),
        .divisor  (step_period_reg),
        .step     (fade_step_reg),
        .rem      (unit_rem),
        .move     (unit_move),
        .stat     (unit_stat)
    );

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_target_reg <= '0;
            fade_step_reg   <= '0;
            step_period_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FADE_TARGET: fade_target_reg <= cfg_data;
                REG_FADE_STEP:   fade_step_reg   <= cfg_data;
                REG_STEP_PERIOD: step_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturation of 16-bit values to full scale
    always_comb begin
        value_ext  = CMP_W'(value_reg);
        target_ext = CMP_W'(fade_target_reg);
        value_sat  = (value_ext > FULL_EXT) ? FULL : LVL_W'(value_ext);
        target_sat = (target_ext > FULL_EXT) ? FULL : LVL_W'(target_ext);
    end

    // tick evaluation: a tick that reaches zero needs the serial unit
    always_comb begin
        tick_live   = (mode_reg == MODE_TICK) && (step_period_reg != '0)
                      && (level_reg != goal_reg);
        need_div    = tick_live && !(countdown_reg > value_reg);
        deficit     = value_reg - countdown_reg;
        rising      = level_reg < goal_reg;
        gap_to_goal = rising ? (goal_reg - level_reg) : (level_reg - goal_reg);
        fading      = level_reg != goal_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EVAL;
            ST_EVAL: state_next = need_div ? ST_DIV : ST_EMIT;
            ST_DIV:  if (unit_stat.done) state_next = ST_EMIT;
            ST_EMIT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        s_ready    = 1'b0;
        unit_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready    = 1'b1;
            ST_EVAL: unit_start = need_div;
            ST_DIV:  ;
            ST_EMIT: load_out   = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign take_in = s_valid && s_ready;

    // ramp state update
    always_comb begin
        level_next     = level_reg;
        goal_next      = goal_reg;
        countdown_next = countdown_reg;
        if (state_reg == ST_EVAL) begin
            case (mode_reg)
                MODE_TICK: begin
                    // countdown stays above zero: just count the ticks down
                    if (tick_live && !need_div) begin
                        countdown_next = countdown_reg - value_reg;
                    end
                end
                MODE_START: begin
                    goal_next      = target_sat;
                    countdown_next = step_period_reg;
                end
                MODE_SET: begin
                    level_next = value_sat;
                    goal_next  = value_sat;
                end
                default: ;
            endcase
        end else if (state_reg == ST_DIV && unit_stat.done) begin
            // reload leaves period minus the deficit remainder
            countdown_next = step_period_reg - unit_rem;
            if (unit_stat.big || unit_move >= gap_to_goal) begin
                level_next = goal_reg;
            end else if (rising) begin
                level_next = level_reg + unit_move;
            end else begin
                level_next = level_reg - unit_move;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            level_reg     <= '0;
            goal_reg      <= '0;
            countdown_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            level_reg     <= level_next;
            goal_reg      <= goal_next;
            countdown_reg <= countdown_next;
        end
    end

    // item capture and result register, payload only
    always_ff @(posedge aclk) begin
        if (take_in) begin
            mode_reg  <= s_mode;
            value_reg <= s_value;
        end
        if (load_out) begin
            out_level_reg   <= DATA_W'(level_reg);
            out_settled_reg <= (step_period_reg == '0) || !fading;
            out_fading_reg  <= fading;
            // level never exceeds full scale, so its top bit marks full
            out_full_reg    <= level_reg[FRACTION_BITS] && !fading;
            out_empty_reg   <= (level_reg == '0) && !fading;
            out_ticks_reg   <= countdown_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_level      = out_level_reg;
    assign m_settled    = out_settled_reg;
    assign m_fading     = out_fading_reg;
    assign m_at_full    = out_full_reg;
    assign m_at_empty   = out_empty_reg;
    assign m_ticks_left = out_ticks_reg;

endmodule

`default_nettype wire

>>> hdl/tpr_checker.sv
// port level checks of the tick paced level ramp and their bind
`default_nettype none

module tpr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [tpr_pkg::IDX_W-1:0]   cfg_index,
    input logic [tpr_pkg::DATA_W-1:0]  cfg_data,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [tpr_pkg::MODE_W-1:0]  s_mode,
    input logic [tpr_pkg::DATA_W-1:0]  s_value,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tpr_pkg::DATA_W-1:0]  m_level,
    input logic                        m_settled,
    input logic                        m_fading,
    input logic                        m_at_full,
    input logic                        m_at_empty,
    input logic [tpr_pkg::CNT_W-1:0]   m_ticks_left
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_ticks_left))
        else $error("result changed while stalled");

    // one item at a time: no input transfer right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // a level at the goal is always settled
    a_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fading |-> m_settled)
        else $error("not fading but not settled");

    // full and empty exclude each other and imply no fade
    a_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_at_full || m_at_empty) |-> !m_fading && !(m_at_full && m_at_empty))
        else $error("inconsistent end flags");

endmodule

bind tick_paced_level_ramp tpr_checker u_tpr_checker (.*);

`default_nettype wire
